@@ hdl/base64_stream_decoder_assert.svh @@
// Assertion macros for the base64 stream decoder.
// Used by the top level; needs nothing else.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define B64D_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define B64D_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hdl/b64d_pkg.sv @@
// Shared types, constants and the character map of the base64 stream decoder.
// No dependencies.
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR       = 8'h3D;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
    localparam logic [7:0] CHAR_PLUS      = 8'h2B;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;

    localparam logic [1:0] GROUP_LAST_POS = 2'd3;
    localparam int         QUEUE_DEPTH_DEF = 4;

    // One unit of work for the output side: a decoded group or an error.
    typedef struct packed {
        logic        err;
        logic        last;
        logic [1:0]  last_idx;
        logic [23:0] triple;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Bit 6 set means the byte is outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] diff;
        diff = 8'd0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            diff = c - CHAR_UPPER_A;
            return {1'b0, diff[5:0]};
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            diff = c - CHAR_LOWER_A + 8'd26;
            return {1'b0, diff[5:0]};
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            diff = c - CHAR_DIGIT_0 + 8'd52;
            return {1'b0, diff[5:0]};
        end else if (c == CHAR_PLUS) begin
            return 7'd62;
        end else if (c == CHAR_SLASH) begin
            return 7'd63;
        end
        return 7'h7F;
    endfunction

endpackage

@@ hdl/b64d_front.sv @@
// Input side of the base64 stream decoder: classifies characters and builds groups.
// Depends on b64d_pkg.
module b64d_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [7:0]               i_char_code,
    input  logic                     i_last_char,
    input  b64d_pkg::t_queue_status  i_q_status,
    output logic                     o_ready,
    output logic                     o_push,
    output b64d_pkg::t_job           o_job
);
    import b64d_pkg::*;

    logic [17:0] r_buf, n_buf;
    logic [1:0]  r_pos, n_pos;
    logic [1:0]  r_pad, n_pad;
    logic        r_err, n_err;

    logic [6:0]  w_map;
    logic        w_is_pad;
    logic        w_bad;
    logic [5:0]  w_sx;
    logic [1:0]  w_drop;
    logic        w_accept;

    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;
    assign w_map    = sextet_of(i_char_code);
    assign w_is_pad = (i_char_code == PAD_CHAR);
    assign w_bad    = (!w_is_pad && w_map[6])
                   || (w_is_pad && (r_pos < 2'd2))
                   || (!w_is_pad && (r_pad != 2'd0));
    assign w_sx     = w_is_pad ? 6'd0 : w_map[5:0];
    assign w_drop   = r_pad + {1'b0, w_is_pad};

    always_comb begin
        n_buf  = r_buf;
        n_pos  = r_pos;
        n_pad  = r_pad;
        n_err  = r_err;
        o_push = 1'b0;
        o_job  = '{err: 1'b1, last: 1'b1, last_idx: 2'd0, triple: 24'd0};
        if (w_accept) begin
            priority if (r_err) begin
                // Discard until the end of the broken stream.
                if (i_last_char) begin
                    n_buf = '0;
                    n_pos = '0;
                    n_pad = '0;
                    n_err = 1'b0;
                end
            end else if (w_bad) begin
                o_push = 1'b1;
                n_buf  = '0;
                n_pos  = '0;
                n_pad  = '0;
                n_err  = !i_last_char;
            end else if (r_pos != GROUP_LAST_POS) begin
                n_buf = {r_buf[11:0], w_sx};
                n_pad = r_pad + {1'b0, w_is_pad};
                n_pos = r_pos + 2'd1;
                if (i_last_char) begin
                    // Stream ends inside a group.
                    o_push = 1'b1;
                    n_buf  = '0;
                    n_pos  = '0;
                    n_pad  = '0;
                end
            end else begin
                o_push       = 1'b1;
                o_job.err    = 1'b0;
                o_job.last   = i_last_char;
                o_job.triple = {r_buf, w_sx};
                priority if (w_drop >= 2'd2) begin
                    o_job.last_idx = 2'd0;
                end else if (w_drop == 2'd1) begin
                    o_job.last_idx = 2'd1;
                end else begin
                    o_job.last_idx = 2'd2;
                end
                n_buf = '0;
                n_pos = '0;
                n_pad = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_pos <= '0;
            r_pad <= '0;
            r_err <= 1'b0;
        end else begin
            r_buf <= n_buf;
            r_pos <= n_pos;
            r_pad <= n_pad;
            r_err <= n_err;
        end
    end

endmodule

@@ hdl/b64d_queue.sv @@
// Small job queue between the input and output sides of the decoder.
// Depends on b64d_pkg.
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  b64d_pkg::t_job           i_job,
    input  logic                     i_pop,
    output b64d_pkg::t_job           o_job,
    output b64d_pkg::t_queue_status  o_status
);
    import b64d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    t_job             r_head;
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_job          = r_head;
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // The head register holds the entry at the read pointer. After a pop it is
    // loaded from the next stored entry, or straight from the incoming job when
    // that job is the only one left in the queue, as after a push into an empty queue.
    always_ff @(posedge i_clk) begin
        if (i_pop && (r_count != CNT_W'(1))) begin
            r_head <= r_mem[n_rd];
        end else if (i_push && (i_pop || (r_count == '0))) begin
            r_head <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

@@ hdl/b64d_back.sv @@
// Output side of the decoder: sends the bytes of each queued job one per cycle while the receiver is ready.
// Depends on b64d_pkg.
module b64d_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  b64d_pkg::t_job           i_job,
    input  b64d_pkg::t_queue_status  i_q_status,
    input  logic                     i_ready,
    output logic                     o_pop,
    output logic                     o_valid,
    output logic [7:0]               o_data_byte,
    output logic                     o_end_of_data,
    output logic                     o_decode_error
);
    import b64d_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       w_at_last;

    assign o_valid        = !i_q_status.empty;
    assign w_at_last      = (r_idx == i_job.last_idx);
    assign o_pop          = o_valid && i_ready && w_at_last;
    assign o_end_of_data  = i_job.last && w_at_last;
    assign o_decode_error = i_job.err;

    always_comb begin
        unique case (r_idx)
            2'd0:    o_data_byte = i_job.triple[23:16];
            2'd1:    o_data_byte = i_job.triple[15:8];
            default: o_data_byte = i_job.triple[7:0];
        endcase
        n_idx = r_idx;
        if (o_valid && i_ready) begin
            n_idx = w_at_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

@@ hdl/base64_stream_decoder.sv @@
// Base64 stream decoder (RFC 4648): top level with the input side, job queue and output side.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back and the assertion header.

// The decoder takes one encoded character per item on the input channel, with a marker on the
// last character of a stream, and gives decoded bytes on the output channel. Every group of four
// characters becomes three bytes, two bytes when the fourth character is '=', and one byte when
// both the third and fourth are '='; the end-of-data flag rides on the final byte of the stream.
// A malformed stream (a byte outside the alphabet, '=' in the first two places of a group, a
// data character after '=', or a stream that stops inside a group) gives one result with the
// error flag and end-of-data set and a zero byte, after which characters are dropped up to and
// including the one that carries the last marker. The input runs at one item per clock while the
// job queue has room. The output side sends one byte per clock while the receiver is ready; a full
// group gives three bytes against the four characters that bring it in, and an error result gives
// one byte for at least one character. The output side therefore keeps up, and over a long stream
// the throughput is one character per clock, set by the input side, as long as the receiver takes
// each byte when it is offered. A job written into an empty queue is offered on the output in the
// next cycle; a group's job is written when its fourth character is taken. The queue of QUEUE_DEPTH
// jobs absorbs stalls of the receiver; once it is full, the input is held off until the output side
// removes a job. There is no clearing pass after reset.
`include "base64_stream_decoder_assert.svh"

module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_data_byte,
    output logic       o_end_of_data,
    output logic       o_decode_error
);
    import b64d_pkg::*;

    // Jobs flow from the front into the queue and out to the back.
    t_job          w_push_job;
    t_job          w_head_job;
    t_queue_status w_q_status;
    logic          w_push;
    logic          w_pop;

    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_q_status  (w_q_status),
        .o_ready     (o_in_ready),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    // The queue holds decoded groups and error markers until the back has sent them.
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_head_job),
        .o_status (w_q_status)
    );

    // The back walks through the bytes of the head job and pops it after its last byte.
    b64d_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (w_head_job),
        .i_q_status     (w_q_status),
        .i_ready        (i_out_ready),
        .o_pop          (w_pop),
        .o_valid        (o_out_valid),
        .o_data_byte    (o_data_byte),
        .o_end_of_data  (o_end_of_data),
        .o_decode_error (o_decode_error)
    );

    // An error result always closes its stream and carries a zero byte.
    `B64D_ASSERT_IMPLIES(a_error_shape, i_clk, i_rst_n,
        o_out_valid && o_decode_error, o_end_of_data && (o_data_byte == 8'd0),
        "error result without end marker or with nonzero byte")

    // The front never writes a job into a full queue.
    `B64D_ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, w_push, !w_q_status.full,
        "job pushed into a full queue")

    // The back never removes a job from an empty queue.
    `B64D_ASSERT_IMPLIES(a_no_underflow, i_clk, i_rst_n, w_pop, !w_q_status.empty,
        "job popped from an empty queue")

    // A push with no pop leaves the queue non-empty in the next cycle.
    `B64D_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, w_push && !w_pop, !w_q_status.empty,
        "queue empty after a push")

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the base64 stream decoder: directed and random character streams.
// Depends on b64d_pkg and the base64_stream_decoder top level; the expected bytes come from a
// behavioral decoder kept inside this file.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    // Least number of items accepted before the closing run of noise bytes.
    localparam int STREAM_ITEMS   = 330;

    // One byte that the decoder is expected to put out.
    typedef struct packed {
        logic [7:0] data;
        logic       eod;
        logic       err;
    } t_byte_result;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [7:0] i_char_code    = 8'd0;
    logic       i_last_char    = 1'b0;
    logic       i_out_ready    = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_data_byte;
    logic       o_end_of_data;
    logic       o_decode_error;

    // Behavioral decoder state, advanced once per accepted item.
    logic [17:0] grp_sextets = '0;
    logic [1:0]  grp_pos     = '0;
    logic [1:0]  grp_pads    = '0;
    logic        discarding  = 1'b0;

    t_byte_result expected_bytes[$];
    int fails        = 0;
    int sent_items   = 0;
    int idle_cycles  = 0;

    // Sender burst control and receiver stall pattern.
    int burst_left  = 0;
    bit idle_on     = 1'b1;
    int stall_mode  = 0;
    int stall_run   = 0;

    base64_stream_decoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_last_char    (i_last_char),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_data_byte    (o_data_byte),
        .o_end_of_data  (o_end_of_data),
        .o_decode_error (o_decode_error)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Value of a character in the alphabet, or -1 when it is not a data character.
    function automatic int sextet_value(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return int'(c) - int'(CHAR_UPPER_A);
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return int'(c) - int'(CHAR_LOWER_A) + 26;
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) return int'(c) - int'(CHAR_DIGIT_0) + 52;
        if (c == CHAR_PLUS) return 62;
        if (c == CHAR_SLASH) return 63;
        return -1;
    endfunction

    function automatic logic [7:0] sextet_char(input int v);
        if (v < 26) return CHAR_UPPER_A + 8'(v);
        if (v < 52) return CHAR_LOWER_A + 8'(v - 26);
        if (v < 62) return CHAR_DIGIT_0 + 8'(v - 52);
        if (v == 62) return CHAR_PLUS;
        return CHAR_SLASH;
    endfunction

    function automatic void push_byte(input logic [7:0] d, input logic eod, input logic err);
        t_byte_result r;
        r.data = d;
        r.eod  = eod;
        r.err  = err;
        expected_bytes = {expected_bytes, r};
    endfunction

    function automatic void clear_group();
        grp_sextets = '0;
        grp_pos     = '0;
        grp_pads    = '0;
    endfunction

    // Advances the decoder state by one character and queues the bytes it gives.
    function automatic void decode_char(input logic [7:0] c, input logic last);
        int          v;
        logic        pad;
        logic        bad;
        logic [23:0] triple;
        int          drop;
        int          n;
        if (discarding) begin
            // Everything up to the last marker is dropped after an error.
            if (last) begin
                clear_group();
                discarding = 1'b0;
            end
            return;
        end
        v   = sextet_value(c);
        pad = (c == PAD_CHAR);
        bad = (!pad && v < 0) || (pad && grp_pos < 2) || (!pad && grp_pads != 0);
        if (bad) begin
            push_byte(8'd0, 1'b1, 1'b1);
            clear_group();
            discarding = !last;
            return;
        end
        if (pad) v = 0;
        if (grp_pos != GROUP_LAST_POS) begin
            grp_sextets = {grp_sextets[11:0], 6'(v)};
            if (pad) grp_pads = grp_pads + 2'd1;
            grp_pos = grp_pos + 2'd1;
            if (last) begin
                // The stream stops inside a group.
                push_byte(8'd0, 1'b1, 1'b1);
                clear_group();
                discarding = 1'b0;
            end
            return;
        end
        triple = {grp_sextets, 6'(v)};
        drop   = int'(grp_pads) + (pad ? 1 : 0);
        n      = (drop >= 2) ? 1 : ((drop == 1) ? 2 : 3);
        for (int k = 0; k < n; k++) begin
            push_byte(triple[23 - 8 * k -: 8], last && (k == n - 1), 1'b0);
        end
        clear_group();
    endfunction

    // Input acceptance feeds the decoder model; output acceptance is checked against it.
    always @(posedge i_clk) begin : monitor
        t_byte_result want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sent_items++;
                decode_char(i_char_code, i_last_char);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected result data=%02h end=%0b err=%0b",
                             $time, o_data_byte, o_end_of_data, o_decode_error);
                    fails++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.data !== o_data_byte) begin
                        $display("%0t: data_byte expected %02h actual %02h",
                                 $time, want.data, o_data_byte);
                        fails++;
                    end
                    if (want.eod !== o_end_of_data) begin
                        $display("%0t: end_of_data expected %0b actual %0b",
                                 $time, want.eod, o_end_of_data);
                        fails++;
                    end
                    if (want.err !== o_decode_error) begin
                        $display("%0t: decode_error expected %0b actual %0b",
                                 $time, want.err, o_decode_error);
                        fails++;
                    end
                end
            end
        end
    end

    // The receiver switches at random between four stall patterns.
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(8, 64);
        end else begin
            stall_run--;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= ($urandom_range(0, 7) != 0);
            default: i_out_ready <= ((stall_run % 8) >= 6);
        endcase
    end

    // Ends the run when no item moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sends one character, opening a random gap at the start of each burst while gaps are enabled.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = idle_on ? $urandom_range(0, 5) : 0;
            repeat (gap) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_text(input string s, input logic last_on_end);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], last_on_end && (i == s.len() - 1));
        end
    endtask

    // Holds the sender off until every expected byte has come out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_bad_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (sextet_value(c) >= 0 || c == PAD_CHAR);
        return c;
    endfunction

    task automatic test_clean_groups();
        send_text("TWFu", 1'b1);
    endtask

    // A padded group first, then the all-ones group.
    task automatic test_padding();
        send_text("TQ==////", 1'b1);
    endtask

    task automatic test_error_cases();
        // Bad character at the start, then the rest of the stream is dropped.
        send_char(8'h00, 1'b0);
        send_char("Z", 1'b1);
        // Padding in the first place, on the last character.
        send_char(PAD_CHAR, 1'b1);
        // Padding in the second place, then a dropped character.
        send_text("A=B", 1'b1);
        // A data character after padding in the third place.
        send_text("TW=u", 1'b1);
        // Stream that stops inside a group.
        send_text("TW", 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    // A stream of whole groups with random content, now and then broken on purpose.
    task automatic send_stream();
        logic [7:0] chars[$];
        int n_groups;
        int pad;
        int g;
        int cut;
        n_groups = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
        for (int gi = 0; gi < n_groups; gi++) begin
            pad = 0;
            if (gi == n_groups - 1 || $urandom_range(0, 15) == 0) pad = $urandom_range(0, 2);
            for (int p = 0; p < 4; p++) begin
                chars = {chars,
                         ((p >= 4 - pad) ? PAD_CHAR : sextet_char($urandom_range(0, 63)))};
            end
        end
        g = $urandom_range(0, n_groups - 1);
        case ($urandom_range(0, 11))
            0: chars[$urandom_range(0, chars.size() - 1)] = random_bad_char();
            1: chars[4 * g + $urandom_range(0, 1)] = PAD_CHAR;
            2: begin
                cut = $urandom_range(1, 3);
                repeat (cut) void'(chars.pop_back());
            end
            3: begin
                chars[4 * g + 2] = PAD_CHAR;
                chars[4 * g + 3] = sextet_char($urandom_range(0, 63));
            end
            default: ;
        endcase
        for (int i = 0; i < chars.size(); i++) begin
            send_char(chars[i], i == chars.size() - 1);
        end
    endtask

    // Raw bytes of any value; the last one carries the marker so the next stream starts clean.
    task automatic test_noise_bytes(input int count);
        for (int i = 0; i < count; i++) begin
            send_char(8'($urandom_range(0, 255)),
                      (i == count - 1) || ($urandom_range(0, 9) == 0));
        end
    endtask

    task automatic test_random_streams();
        bit paused;
        paused = 1'b0;
        while (sent_items < STREAM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                test_noise_bytes($urandom_range(1, 12));
            end else begin
                send_stream();
            end
            if (!paused && sent_items > STREAM_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_clean_groups();
        test_padding();
        test_error_cases();
        wait_drained();
        test_random_streams();
        test_noise_bytes(40);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_bytes.size() != 0) begin
            $display("%0t: %0d expected results never came", $time, expected_bytes.size());
            fails++;
        end
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
